// File: rtl/lfir_pkg.sv
package lfir_pkg;

   localparam int TAPS       = 9;
   localparam int PIXEL_BITS = 8;
   localparam int MAX_ROW    = 4096;

   localparam int PIXEL_FIELD_BITS = 8;
   localparam int INDEX_BITS       = 4;
   localparam int COEF_BITS        = 16;
   localparam int SUM_BITS         = 28;
   localparam int ROW_BITS         = 13;

   localparam int COUNT_BITS = $clog2(MAX_ROW + 1);
   localparam int LIMIT_BITS = (COUNT_BITS > ROW_BITS) ? COUNT_BITS : ROW_BITS;

   localparam int PROD_BITS = PIXEL_BITS + 1 + COEF_BITS;
   localparam int GROUP     = 4;
   localparam int GROUPS    = (TAPS + GROUP - 1) / GROUP;
   localparam int GSUM_BITS = PROD_BITS + $clog2(GROUP);
   localparam int ACC_BITS  = GSUM_BITS + $clog2(GROUPS) + 1;

   localparam int CENTRE_TAP = TAPS / 2;

   localparam int PIXEL_LSB  = 0;
   localparam int INDEX_LSB  = PIXEL_LSB + PIXEL_FIELD_BITS;
   localparam int WEIGHT_LSB = INDEX_LSB + INDEX_BITS;

   localparam int REQ_TDATA_BITS = 32;
   localparam int RSP_TDATA_BITS = 40;
   localparam int CSR_DATA_BITS  = 28;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_COEF  = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_LENGTH = 1'b1;

   localparam logic [ROW_BITS-1:0] ROW_LENGTH_RESET = 13'd1024;

   typedef logic [PIXEL_BITS-1:0]              pixel_type;
   typedef logic signed [COEF_BITS-1:0]        coef_type;
   typedef logic signed [PROD_BITS-1:0]        prod_type;
   typedef prod_type [TAPS-1:0]                prod_row_type;
   typedef logic signed [SUM_BITS-1:0]         sum_type;
   typedef logic [ROW_BITS-1:0]                row_type;

   typedef struct packed {
      logic                        valid;
      logic [PIXEL_FIELD_BITS-1:0] centre;
   } stage_type;

endpackage

// File: rtl/lfir_cell.sv
module lfir_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  lfir_pkg::pixel_type pixel_in,
   output lfir_pkg::pixel_type pixel_out,
   input  logic                coef_we,
   input  lfir_pkg::coef_type  coef_data,
   output lfir_pkg::prod_type  prod_out
);
   import lfir_pkg::*;

   pixel_type pixel_ff;
   coef_type  coef_ff;
   prod_type  prod_ff;
   prod_type  prod_in;

   assign prod_in = $signed({1'b0, pixel_in}) * coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (coef_we) begin
         coef_ff <= coef_data;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         pixel_ff <= pixel_in;
         prod_ff  <= prod_in;
      end
   end

   assign pixel_out = pixel_ff;
   assign prod_out  = prod_ff;

endmodule

// File: rtl/lfir_col_ctrl.sv
module lfir_col_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              pixel_take,
   input  lfir_pkg::row_type row_length,
   output logic              emit
);
   import lfir_pkg::*;

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [COUNT_BITS-1:0] count_inc;
   logic [LIMIT_BITS-1:0] row_wide;
   logic [LIMIT_BITS-1:0] limit;
   logic [LIMIT_BITS-1:0] inc_wide;

   always_comb begin
      count_inc = (count_ff == COUNT_BITS'(MAX_ROW)) ? count_ff : count_ff + 1'b1;
      inc_wide  = LIMIT_BITS'(count_inc);
      row_wide  = LIMIT_BITS'(row_length);
      limit     = (row_wide > LIMIT_BITS'(MAX_ROW)) ? LIMIT_BITS'(MAX_ROW) : row_wide;
      emit      = pixel_take && (inc_wide >= LIMIT_BITS'(TAPS)) && (inc_wide <= limit);
      count_in  = count_ff;
      if (pixel_take) begin
         count_in = (inc_wide >= limit) ? '0 : count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/lfir_sum.sv
module lfir_sum (
   input  logic                   clock,
   input  logic                   reset,
   input  lfir_pkg::stage_type    stage_in,
   input  lfir_pkg::prod_row_type prods,
   input  lfir_pkg::sum_type      threshold,
   output logic                   take_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output lfir_pkg::sum_type      weighted_sum,
   output logic                   above_threshold,
   output logic [lfir_pkg::PIXEL_FIELD_BITS-1:0] centre_pixel
);
   import lfir_pkg::*;

   localparam logic signed [ACC_BITS-1:0] ACC_MAX = ACC_BITS'((2 ** (SUM_BITS - 1)) - 1);
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = ACC_BITS'(-(2 ** (SUM_BITS - 1)));

   logic signed [GSUM_BITS-1:0] gsum_ff [GROUPS];
   logic signed [GSUM_BITS-1:0] gsum_in [GROUPS];
   logic                        v2_ff;
   logic                        v2_in;
   logic [PIXEL_FIELD_BITS-1:0] centre2_ff;
   logic                        v3_ff;
   logic                        v3_in;
   sum_type                     sum3_ff;
   sum_type                     sum3_in;
   logic                        above3_ff;
   logic [PIXEL_FIELD_BITS-1:0] centre3_ff;
   logic signed [ACC_BITS-1:0]  total;
   logic                        free2;
   logic                        free3;

   assign free3 = !v3_ff || out_ready;
   assign free2 = !v2_ff || free3;
   assign v2_in = free2 ? stage_in.valid : v2_ff;
   assign v3_in = free3 ? v2_ff : v3_ff;

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         gsum_in[g] = '0;
         for (int j = 0; j < GROUP; j++) begin
            if (g * GROUP + j < TAPS) begin
               gsum_in[g] = gsum_in[g] + GSUM_BITS'($signed(prods[g * GROUP + j]));
            end
         end
      end
   end

   always_comb begin
      total = '0;
      for (int g = 0; g < GROUPS; g++) begin
         total = total + ACC_BITS'(gsum_ff[g]);
      end
      if (total > ACC_MAX) begin
         sum3_in = SUM_BITS'(ACC_MAX);
      end else if (total < ACC_MIN) begin
         sum3_in = SUM_BITS'(ACC_MIN);
      end else begin
         sum3_in = total[SUM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free2) begin
         gsum_ff    <= gsum_in;
         centre2_ff <= stage_in.centre;
      end
      if (free3) begin
         sum3_ff    <= sum3_in;
         above3_ff  <= (sum3_in >= threshold);
         centre3_ff <= centre2_ff;
      end
   end

   assign take_ready      = free2;
   assign out_valid       = v3_ff;
   assign weighted_sum    = sum3_ff;
   assign above_threshold = above3_ff;
   assign centre_pixel    = centre3_ff;

endmodule

// File: rtl/line_fir_threshold_detector_top.sv
// A pixel word's result passes the registered cell products, group sums and final sum before it shows on rsp_tvalid.
// Throughput: one input word per cycle, pixel or coefficient, while the result side keeps up.
// Each pixel passes the cell row with its multipliers, one group adder stage and one final
// add, saturate and compare stage; a stalled result admits two more result-producing pixels.
// Synchronous reset clears the pipeline, the column count, all coefficients, the
// threshold (to zero) and the row length (to 1024).
module line_fir_threshold_detector_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // pixel[7:0], tap_index[11:8], tap_weight[27:12], zero fill
   input  logic [lfir_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // operation[0]
   input  logic [0:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // weighted_sum[27:0], above_threshold[28], centre_pixel[36:29], zero fill
   output logic [lfir_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lfir_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lfir_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import lfir_pkg::*;

   sum_type      threshold_ff;
   row_type      row_length_ff;
   logic         v1_ff;
   logic         v1_in;
   logic [PIXEL_FIELD_BITS-1:0] centre1_ff;
   logic         free1;
   logic         free2;
   logic         accept;
   logic         pixel_take;
   logic         coef_take;
   logic         emit;
   pixel_type    new_pixel;
   logic [INDEX_BITS-1:0] tap_index;
   coef_type     tap_weight;
   pixel_type    win_in  [TAPS];
   pixel_type    win_out [TAPS];
   prod_row_type prods;
   stage_type    stage1;
   sum_type      weighted_sum;
   logic         above_threshold;
   logic [PIXEL_FIELD_BITS-1:0] centre_pixel;

   assign accept     = req_tvalid && req_tready;
   assign pixel_take = accept && (req_tuser[0] == OP_PIXEL);
   assign coef_take  = accept && (req_tuser[0] == OP_COEF);
   assign new_pixel  = PIXEL_BITS'(req_tdata[PIXEL_LSB +: PIXEL_FIELD_BITS]);
   assign tap_index  = req_tdata[INDEX_LSB +: INDEX_BITS];
   assign tap_weight = req_tdata[WEIGHT_LSB +: COEF_BITS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= '0;
         row_length_ff <= ROW_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_THRESHOLD:  threshold_ff  <= csr_data[SUM_BITS-1:0];
            CSR_ROW_LENGTH: row_length_ff <= csr_data[ROW_BITS-1:0];
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < TAPS; i++) begin : g_cell
      if (i == TAPS - 1) begin : g_head
         assign win_in[i] = new_pixel;
      end else begin : g_link
         assign win_in[i] = win_out[i + 1];
      end

      lfir_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (pixel_take),
         .pixel_in  (win_in[i]),
         .pixel_out (win_out[i]),
         .coef_we   (coef_take && (tap_index == INDEX_BITS'(i))),
         .coef_data (tap_weight),
         .prod_out  (prods[i])
      );
   end

   lfir_col_ctrl u_col_ctrl (
      .clock      (clock),
      .reset      (reset),
      .pixel_take (pixel_take),
      .row_length (row_length_ff),
      .emit       (emit)
   );

   assign free1      = !v1_ff || free2;
   assign req_tready = free1;
   assign v1_in      = free1 ? emit : v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_take) begin
         centre1_ff <= PIXEL_FIELD_BITS'(win_in[CENTRE_TAP]);
      end
   end

   assign stage1.valid  = v1_ff;
   assign stage1.centre = centre1_ff;

   lfir_sum u_sum (
      .clock           (clock),
      .reset           (reset),
      .stage_in        (stage1),
      .prods           (prods),
      .threshold       (threshold_ff),
      .take_ready      (free2),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .weighted_sum    (weighted_sum),
      .above_threshold (above_threshold),
      .centre_pixel    (centre_pixel)
   );

   assign rsp_tdata = RSP_TDATA_BITS'({centre_pixel, above_threshold, weighted_sum});

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !v1_ff && !rsp_tvalid)
      else $error("pipeline not empty after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !free2 |=> v1_ff)
      else $error("stalled first stage lost its word");

   a_coef_no_result: assert property (@(posedge clock) disable iff (reset)
      coef_take |=> !v1_ff)
      else $error("coefficient write produced a result");

   a_accept_space: assert property (@(posedge clock) disable iff (reset)
      accept |-> !v1_ff || free2)
      else $error("word accepted with first stage blocked");
`endif

endmodule

// File: dv/tb_line_fir_threshold_detector_top.sv
module tb_line_fir_threshold_detector_top;
   import lfir_pkg::*;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int RANDOM_PHASES   = 24;
   localparam int HOLD_PHASE      = 5;
   localparam int PRINT_CAP       = 100;

   typedef enum {PACE_NONE, PACE_LIGHT, PACE_FULL} pace_type;
   typedef enum {STEP_WORD, STEP_CSR} step_kind_type;

   typedef struct packed {
      pixel_type centre;
      logic      above;
      sum_type   weighted_sum;
   } filter_result_type;

   typedef struct {
      step_kind_type             kind;
      logic                      op;
      logic [REQ_TDATA_BITS-1:0] word;
      logic [CSR_INDEX_BITS-1:0] csr_idx;
      logic [CSR_DATA_BITS-1:0]  csr_val;
      bit                        known;
      filter_result_type         result;
   } script_row_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata;
   logic [0:0]                req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   pixel_type      window_px [TAPS];
   coef_type       tap_coef [TAPS];
   int             col_count;
   sum_type        thr_reg;
   row_type        row_len_reg;

   filter_result_type pending_results [$];
   bit                known_pending;
   filter_result_type known_value;
   bit                hold_off_pending;
   pace_type          send_pace;
   pace_type          recv_pace;
   int                mismatch_count;
   int                quiet_cycles;

   line_fir_threshold_detector_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_gap(input pace_type pace);
      case (pace)
         PACE_NONE:  return 0;
         PACE_LIGHT: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
         default:    return $urandom_range(0, 17);
      endcase
   endfunction

   function automatic logic [REQ_TDATA_BITS-1:0] pack_word(input pixel_type px,
                                                          input logic [INDEX_BITS-1:0] tap,
                                                          input coef_type w);
      logic [REQ_TDATA_BITS-1:0] word;
      word = '0;
      word[PIXEL_LSB +: PIXEL_BITS] = px;
      word[INDEX_LSB +: INDEX_BITS] = tap;
      word[WEIGHT_LSB +: COEF_BITS] = w;
      return word;
   endfunction

   function automatic script_row_type pixel_row(input pixel_type px);
      script_row_type r;
      r.kind    = STEP_WORD;
      r.op      = OP_PIXEL;
      r.word    = pack_word(px, '0, '0);
      r.csr_idx = '0;
      r.csr_val = '0;
      r.known   = 1'b0;
      r.result  = '0;
      return r;
   endfunction

   function automatic script_row_type pixel_row_known(input pixel_type px, input sum_type s,
                                                      input logic a, input pixel_type c);
      script_row_type r;
      r = pixel_row(px);
      r.known               = 1'b1;
      r.result.weighted_sum = s;
      r.result.above        = a;
      r.result.centre       = c;
      return r;
   endfunction

   function automatic script_row_type coef_row(input logic [INDEX_BITS-1:0] tap,
                                               input coef_type w);
      script_row_type r;
      r = pixel_row('0);
      r.op   = OP_COEF;
      r.word = pack_word('0, tap, w);
      return r;
   endfunction

   function automatic script_row_type csr_row(input logic [CSR_INDEX_BITS-1:0] idx,
                                              input logic [CSR_DATA_BITS-1:0] val);
      script_row_type r;
      r = pixel_row('0);
      r.kind    = STEP_CSR;
      r.csr_idx = idx;
      r.csr_val = val;
      return r;
   endfunction

   function automatic bit advance_filter(input logic op, input logic [REQ_TDATA_BITS-1:0] word,
                                         output filter_result_type res);
      logic [INDEX_BITS-1:0] tap;
      longint                acc;
      int                    lim;
      bit                    made;
      res  = '0;
      made = 1'b0;
      tap  = word[INDEX_LSB +: INDEX_BITS];
      if (op == OP_COEF) begin
         if (tap < TAPS) tap_coef[tap] = coef_type'(word[WEIGHT_LSB +: COEF_BITS]);
         return 1'b0;
      end
      for (int i = 0; i < TAPS - 1; i++) window_px[i] = window_px[i + 1];
      window_px[TAPS - 1] = word[PIXEL_LSB +: PIXEL_BITS];
      if (col_count < MAX_ROW) col_count++;
      lim = (row_len_reg > MAX_ROW) ? MAX_ROW : int'(row_len_reg);
      if (col_count >= TAPS && col_count <= lim) begin
         acc = 0;
         for (int i = 0; i < TAPS; i++) begin
            acc += longint'({1'b0, window_px[i]}) * longint'(tap_coef[i]);
         end
         if (acc > 64'sd134217727) acc = 64'sd134217727;
         if (acc < -64'sd134217728) acc = -64'sd134217728;
         res.weighted_sum = sum_type'(acc);
         res.above        = (acc >= longint'(thr_reg));
         res.centre       = window_px[CENTRE_TAP];
         made             = 1'b1;
      end
      if (col_count >= lim) begin
         for (int i = 0; i < TAPS; i++) window_px[i] = '0;
         col_count = 0;
      end
      return made;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP) $display("Mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      filter_result_type res;
      filter_result_type want;
      sum_type           got_sum;
      logic              got_above;
      pixel_type         got_centre;
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            window_px[i] = '0;
            tap_coef[i]  = '0;
         end
         col_count    = 0;
         thr_reg      = '0;
         row_len_reg  = ROW_LENGTH_RESET;
         quiet_cycles = 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THRESHOLD:  thr_reg = sum_type'(csr_data[SUM_BITS-1:0]);
               CSR_ROW_LENGTH: row_len_reg = csr_data[ROW_BITS-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (advance_filter(req_tuser[0], req_tdata, res)) begin
               pending_results = {pending_results, (known_pending ? known_value : res)};
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got_sum    = sum_type'(rsp_tdata[SUM_BITS-1:0]);
            got_above  = rsp_tdata[SUM_BITS];
            got_centre = rsp_tdata[SUM_BITS+1 +: PIXEL_BITS];
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result word with nothing expected, sum %0d",
                                         got_sum));
            end else begin
               want = pending_results.pop_front();
               if (got_sum !== want.weighted_sum)
                  report_mismatch($sformatf("weighted_sum %0d, expected %0d",
                                            got_sum, want.weighted_sum));
               if (got_above !== want.above)
                  report_mismatch($sformatf("above_threshold %0b, expected %0b",
                                            got_above, want.above));
               if (got_centre !== want.centre)
                  report_mismatch($sformatf("centre_pixel %0d, expected %0d",
                                            got_centre, want.centre));
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap(recv_pace);
         if (hold_off_pending) begin
            gap              = HOLD_OFF_CYCLES;
            hold_off_pending = 1'b0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic send_word(input logic op, input logic [REQ_TDATA_BITS-1:0] word,
                            input bit known, input filter_result_type want);
      int gap;
      gap = draw_gap(send_pace);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid    <= 1'b1;
      req_tuser     <= op;
      req_tdata     <= word;
      known_pending  = known;
      known_value    = want;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      script_row_type            script [$];
      int                        n;
      int                        roll;
      logic                      op;
      pixel_type                 px;
      coef_type                  w;
      logic [INDEX_BITS-1:0]     tap;
      logic [CSR_DATA_BITS-1:0]  thr_val;
      logic [ROW_BITS-1:0]       row_val;

      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      known_pending    = 1'b0;
      known_value      = '0;
      hold_off_pending = 1'b0;
      send_pace        = PACE_LIGHT;
      recv_pace        = PACE_LIGHT;
      mismatch_count   = 0;

      // All taps are zero after reset, so the first full window sums to zero,
      // which meets the zero threshold.
      script = '{
         pixel_row(8'hFF), pixel_row(8'h00), pixel_row(8'h80), pixel_row(8'h01),
         pixel_row(8'hAA), pixel_row(8'h55), pixel_row(8'h7F), pixel_row(8'hFE),
         pixel_row_known(8'hFF, 28'sd0, 1'b1, 8'hAA),
         coef_row(4'd0, 16'sh8000), coef_row(4'd8, 16'sh7FFF),
         coef_row(4'd4, 16'sd1), coef_row(4'd15, 16'shFFFF),
         pixel_row(8'hFF),
         csr_row(CSR_THRESHOLD, 28'h7FF_FFFF), pixel_row(8'h00),
         csr_row(CSR_THRESHOLD, 28'h800_0000), pixel_row(8'h80),
         csr_row(CSR_ROW_LENGTH, 28'd0), pixel_row(8'h12), pixel_row(8'h34),
         csr_row(CSR_ROW_LENGTH, 28'd9),
         pixel_row(8'h5A), pixel_row(8'hA5), pixel_row(8'hC3), pixel_row(8'h3C),
         pixel_row(8'h0F), pixel_row(8'hF0), pixel_row(8'h99), pixel_row(8'h66),
         pixel_row(8'hFF)
      };

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         if (script[k].kind == STEP_CSR) begin
            wait_idle();
            write_csr(script[k].csr_idx, script[k].csr_val);
         end else begin
            send_word(script[k].op, script[k].word, script[k].known, script[k].result);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         send_pace = pace_type'($urandom_range(0, 2));
         recv_pace = pace_type'($urandom_range(0, 2));

         if (phase == 0 || $urandom_range(0, 1) == 1) begin
            roll = $urandom_range(0, 19);
            if (roll < 3) thr_val = 28'h7FF_FFFF;
            else if (roll < 6) thr_val = 28'h800_0000;
            else if (roll < 8) thr_val = '0;
            else thr_val = CSR_DATA_BITS'($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000);
            write_csr(CSR_THRESHOLD, thr_val);
         end

         roll = $urandom_range(0, 19);
         if (roll < 13) row_val = ROW_BITS'($urandom_range(16, 48));
         else if (roll < 15) row_val = ROW_BITS'($urandom_range(0, TAPS - 1));
         else if (roll == 15) row_val = ROW_BITS'($urandom_range(TAPS, 15));
         else if (roll == 16) row_val = ROW_BITS'(MAX_ROW);
         else if (roll == 17) row_val = ROW_BITS'($urandom_range(MAX_ROW + 1, 8190));
         else if (roll == 18) row_val = 13'h1FFF;
         else row_val = ROW_BITS'($urandom_range(49, 1024));
         if (phase == HOLD_PHASE) begin
            row_val   = 13'd20;
            send_pace = PACE_NONE;
         end
         write_csr(CSR_ROW_LENGTH, {{(CSR_DATA_BITS-ROW_BITS){1'b0}}, row_val});

         // The receiver stops for a long stretch while pixels keep coming.
         if (phase == HOLD_PHASE) hold_off_pending = 1'b1;

         n = $urandom_range(60, 100);
         repeat (n) begin
            op   = ($urandom_range(0, 7) == 0) ? OP_COEF : OP_PIXEL;
            roll = $urandom_range(0, 9);
            if (roll == 0) px = '0;
            else if (roll == 1) px = '1;
            else px = pixel_type'($urandom);
            roll = $urandom_range(0, 9);
            if (roll == 0) w = 16'sh8000;
            else if (roll == 1) w = 16'sh7FFF;
            else w = coef_type'($urandom);
            tap = INDEX_BITS'($urandom);
            send_word(op, pack_word(px, tap, w), 1'b0, '0);
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: line_fir_threshold_detector_top.f
rtl/lfir_pkg.sv
rtl/lfir_cell.sv
rtl/lfir_col_ctrl.sv
rtl/lfir_sum.sv
rtl/line_fir_threshold_detector_top.sv
dv/tb_line_fir_threshold_detector_top.sv
